FILE: rtl/core/sha512_pkg.sv
package sha512_pkg;

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  byte_count;
        logic        message_end;
    } t_in_word;

    typedef struct packed {
        logic [63:0] digest_word;
        logic        digest_last;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned LEN_SLOT = 14;
    localparam logic [0:0] REG_MODE = 1'b0;

    function automatic logic [63:0] round_k(input logic [6:0] r);
        logic [63:0] k;
        unique case (r)
            7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

    function automatic logic [63:0] init_hash(input logic mode, input logic [2:0] i);
        logic [63:0] h;
        unique case ({mode, i})
            4'd0: h = 64'h6a09e667f3bcc908; 4'd1: h = 64'hbb67ae8584caa73b;
            4'd2: h = 64'h3c6ef372fe94f82b; 4'd3: h = 64'ha54ff53a5f1d36f1;
            4'd4: h = 64'h510e527fade682d1; 4'd5: h = 64'h9b05688c2b3e6c1f;
            4'd6: h = 64'h1f83d9abfb41bd6b; 4'd7: h = 64'h5be0cd19137e2179;
            4'd8: h = 64'hcbbb9d5dc1059ed8; 4'd9: h = 64'h629a292a367cd507;
            4'd10: h = 64'h9159015a3070dd17; 4'd11: h = 64'h152fecd8f70e5939;
            4'd12: h = 64'h67332667ffc00b31; 4'd13: h = 64'h8eb44a8768581511;
            4'd14: h = 64'hdb0c2e0d64f98fa7; default: h = 64'h47b5481dbefa4fa4;
        endcase
        return h;
    endfunction

endpackage

FILE: rtl/core/sha512_hash_engine.sv
// A word that does not fill a block is taken in IDLE and stored in PUSH; one
// that fills a block then runs the rounds and a fold (one chain word each step).
// A closing word pads one word per cycle while no filled block is hashed, runs
// one or two blocks, then shows 8 (or 6) digest words, one per cycle as taken.
// One round unit; no input taken while hashing. Synchronous reset loads SHA-512 IVs.
module sha512_hash_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sha512_pkg::t_in_word  i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sha512_pkg::t_out_word o_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [1:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    sha512_pkg::t_state r_state, n_state;
    logic        r_mode;
    logic [63:0] r_h [8];
    logic [63:0] r_v [8];
    logic [63:0] r_w [16];
    logic [3:0]  r_wb;
    logic [60:0] r_bytes;
    logic [6:0]  r_rnd;
    logic [2:0]  r_idx;
    // padding sequencer
    logic        r_pad;      // closing sequence active
    logic [1:0]  r_pad_ph;   // 0 first word, 1 marker, 2 zeros/len, 3 marked word
    logic [63:0] r_first;
    logic [63:0] push_val;
    logic        push_last;  // length word is being pushed
    logic        r_out_pend;

    logic        cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = {31'd0, r_mode};

    logic [3:0]  n_cnt;
    logic [63:0] keep;
    always_comb begin
        n_cnt = (i_data.byte_count > 4'd8) ? 4'd8 : i_data.byte_count;
        keep = ~64'd0 << (7'd64 - {n_cnt[3:0], 3'd0});
        if (n_cnt == 4'd0) keep = 64'd0;
    end

    // pushing a word into the buffer
    always_comb begin
        push_val = 64'd0;
        push_last = 1'b0;
        unique case (r_pad_ph)
            2'd0, 2'd3: push_val = r_first;
            2'd1: push_val = {sha512_pkg::PAD_BYTE, 56'd0};
            default: begin
                // marker in slot 14 leaves no room for the length
                if (r_wb == 4'd15 && r_w[14] == 64'd0) begin
                    push_val = {r_bytes, 3'd0};
                    push_last = 1'b1;
                end
            end
        endcase
    end

    // schedule and round datapath
    logic [63:0] w_cur, w2, w15, s0, s1, t1, t2;
    logic [3:0]  ri;
    always_comb begin
        ri = r_rnd[3:0];
        w2 = r_w[ri - 4'd2];
        w15 = r_w[ri - 4'd15];
        s1 = {w2[18:0], w2[63:19]} ^ {w2[60:0], w2[63:61]} ^ (w2 >> 6);
        s0 = {w15[0], w15[63:1]} ^ {w15[7:0], w15[63:8]} ^ (w15 >> 7);
        w_cur = (r_rnd < 7'd16) ? r_w[ri] : s1 + r_w[ri - 4'd7] + s0 + r_w[ri];
        t1 = r_v[7] + ({r_v[4][13:0], r_v[4][63:14]} ^ {r_v[4][17:0], r_v[4][63:18]}
             ^ {r_v[4][40:0], r_v[4][63:41]}) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + sha512_pkg::round_k(r_rnd) + w_cur;
        t2 = ({r_v[0][27:0], r_v[0][63:28]} ^ {r_v[0][33:0], r_v[0][63:34]}
             ^ {r_v[0][38:0], r_v[0][63:39]})
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    logic [2:0] last_idx;
    assign last_idx = r_mode ? 3'd5 : 3'd7;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha512_pkg::ST_IDLE: if (i_valid) n_state = sha512_pkg::ST_PUSH;
            sha512_pkg::ST_PUSH: begin
                if (r_wb == 4'd15) n_state = sha512_pkg::ST_ROUND;
                else if (push_last) n_state = sha512_pkg::ST_OUT;
                else if (!r_pad) n_state = sha512_pkg::ST_IDLE;
            end
            sha512_pkg::ST_ROUND: if (r_rnd == 7'd79) n_state = sha512_pkg::ST_FOLD;
            sha512_pkg::ST_FOLD: begin
                if (r_idx == 3'd7) begin
                    if (r_out_pend) n_state = sha512_pkg::ST_OUT;
                    else if (r_pad) n_state = sha512_pkg::ST_PUSH;
                    else n_state = sha512_pkg::ST_IDLE;
                end
            end
            sha512_pkg::ST_OUT: if (i_ready && r_idx == last_idx) n_state = sha512_pkg::ST_IDLE;
            default: n_state = sha512_pkg::ST_IDLE;
        endcase
        if (cfg_wr) n_state = sha512_pkg::ST_IDLE;
    end

    always_comb begin
        o_ready = (r_state == sha512_pkg::ST_IDLE) && !cfg_wr;
        o_valid = (r_state == sha512_pkg::ST_OUT);
        o_data.digest_word = r_h[r_idx];
        o_data.digest_last = (r_idx == last_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha512_pkg::ST_IDLE;
            r_mode <= 1'b0;
            r_wb <= 4'd0;
            r_bytes <= 61'd0;
            r_rnd <= 7'd0;
            r_idx <= 3'd0;
            r_pad <= 1'b0;
            r_pad_ph <= 2'd0;
            r_out_pend <= 1'b0;
            for (int j = 0; j < 8; j++) begin
                r_h[j] <= sha512_pkg::init_hash(1'b0, 3'(j));
                r_v[j] <= 64'd0;
            end
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                if (paddr[1:0] == {1'b0, sha512_pkg::REG_MODE}) begin
                    r_mode <= pwdata[0];
                    for (int j = 0; j < 8; j++) r_h[j] <= sha512_pkg::init_hash(pwdata[0], 3'(j));
                    r_wb <= 4'd0;
                    r_bytes <= 61'd0;
                    r_pad <= 1'b0;
                    r_out_pend <= 1'b0;
                    r_idx <= 3'd0;
                end
            end else begin
                unique case (r_state)
                    sha512_pkg::ST_IDLE: if (i_valid) begin
                        r_pad <= i_data.message_end;
                        r_pad_ph <= (i_data.message_end && n_cnt != 4'd8) ? 2'd2 : 2'd0;
                        r_first <= i_data.message_end
                            ? ((n_cnt == 4'd8) ? i_data.message_word
                              : (i_data.message_word & keep)
                                | ({sha512_pkg::PAD_BYTE, 56'd0} >> {n_cnt[2:0], 3'd0}))
                            : i_data.message_word;
                        r_bytes <= r_bytes + (i_data.message_end ? 61'(n_cnt) : 61'd8);
                        if (i_data.message_end && n_cnt != 4'd8) r_pad_ph <= 2'd3;
                    end
                    sha512_pkg::ST_PUSH: begin
                        r_w[r_wb] <= (r_pad_ph == 2'd3) ? r_first : push_val;
                        r_wb <= r_wb + 4'd1;
                        if (r_pad_ph == 2'd0) r_pad_ph <= 2'd1;
                        else if (r_pad_ph != 2'd2) r_pad_ph <= 2'd2;
                        if (push_last) begin
                            r_pad <= 1'b0;
                            r_out_pend <= 1'b1;
                        end
                        r_rnd <= 7'd0;
                        for (int j = 0; j < 8; j++) r_v[j] <= r_h[j];
                        r_idx <= 3'd0;
                    end
                    sha512_pkg::ST_ROUND: begin
                        r_w[ri] <= w_cur;
                        r_rnd <= r_rnd + 7'd1;
                        for (int j = 1; j < 8; j++) if (j != 4) r_v[j] <= r_v[j-1];
                        r_v[4] <= r_v[3] + t1;
                        r_v[0] <= t1 + t2;
                    end
                    sha512_pkg::ST_FOLD: begin
                        r_h[r_idx] <= r_h[r_idx] + r_v[r_idx];
                        r_idx <= r_idx + 3'd1;
                    end
                    sha512_pkg::ST_OUT: if (i_ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == last_idx) begin
                            r_out_pend <= 1'b0;
                            r_idx <= 3'd0;
                            r_wb <= 4'd0;
                            r_bytes <= 61'd0;
                            for (int j = 0; j < 8; j++)
                                r_h[j] <= sha512_pkg::init_hash(r_mode, 3'(j));
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // unpadded non-final word: no pad phases, so leave PUSH after one word
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("accepting during digest output");
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha512_pkg::ST_ROUND) |-> (r_rnd < 7'd80)) else $error("round overrun");
    a_last_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_data.digest_last && !cfg_wr) |=> !o_valid)
        else $error("digest beyond last word");
    a_out_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_wb == 4'd0)) else $error("buffer not empty at digest");

endmodule

FILE: sim/sha512_hash_engine_test.sv
module sha512_hash_engine_test;

    localparam int unsigned IDLE_LIMIT = 20000;
    localparam logic [1:0] ADDR_MODE = 2'd0;

    class digest_scoreboard;
        logic [63:0] chain[8];
        logic [63:0] window[16];
        logic [3:0]  filled;
        logic [60:0] byte_total;
        logic        sha384;
        sha512_pkg::t_out_word pending[$];
        int          errors;

        function new();
            errors = 0;
            sha384 = 1'b0;
            load_iv();
        endfunction

        function void load_iv();
            logic [63:0] iv512[8];
            logic [63:0] iv384[8];
            iv512 = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
                      64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
                      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
            iv384 = '{64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
                      64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
                      64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};
            for (int i = 0; i < 8; i++) chain[i] = sha384 ? iv384[i] : iv512[i];
            filled = 0;
            byte_total = 0;
        endfunction

        function void set_mode(logic m);
            sha384 = m;
            load_iv();
        endfunction

        function logic [63:0] ror(logic [63:0] x, int n);
            return (x >> n) | (x << (64 - n));
        endfunction

        function logic [63:0] kconst(int r);
            logic [63:0] k[80];
            k = '{
            64'h428a2f98d728ae22,64'h7137449123ef65cd,64'hb5c0fbcfec4d3b2f,64'he9b5dba58189dbbc,
            64'h3956c25bf348b538,64'h59f111f1b605d019,64'h923f82a4af194f9b,64'hab1c5ed5da6d8118,
            64'hd807aa98a3030242,64'h12835b0145706fbe,64'h243185be4ee4b28c,64'h550c7dc3d5ffb4e2,
            64'h72be5d74f27b896f,64'h80deb1fe3b1696b1,64'h9bdc06a725c71235,64'hc19bf174cf692694,
            64'he49b69c19ef14ad2,64'hefbe4786384f25e3,64'h0fc19dc68b8cd5b5,64'h240ca1cc77ac9c65,
            64'h2de92c6f592b0275,64'h4a7484aa6ea6e483,64'h5cb0a9dcbd41fbd4,64'h76f988da831153b5,
            64'h983e5152ee66dfab,64'ha831c66d2db43210,64'hb00327c898fb213f,64'hbf597fc7beef0ee4,
            64'hc6e00bf33da88fc2,64'hd5a79147930aa725,64'h06ca6351e003826f,64'h142929670a0e6e70,
            64'h27b70a8546d22ffc,64'h2e1b21385c26c926,64'h4d2c6dfc5ac42aed,64'h53380d139d95b3df,
            64'h650a73548baf63de,64'h766a0abb3c77b2a8,64'h81c2c92e47edaee6,64'h92722c851482353b,
            64'ha2bfe8a14cf10364,64'ha81a664bbc423001,64'hc24b8b70d0f89791,64'hc76c51a30654be30,
            64'hd192e819d6ef5218,64'hd69906245565a910,64'hf40e35855771202a,64'h106aa07032bbd1b8,
            64'h19a4c116b8d2d0c8,64'h1e376c085141ab53,64'h2748774cdf8eeb99,64'h34b0bcb5e19b48a8,
            64'h391c0cb3c5c95a63,64'h4ed8aa4ae3418acb,64'h5b9cca4f7763e373,64'h682e6ff3d6b2b8a3,
            64'h748f82ee5defb2fc,64'h78a5636f43172f60,64'h84c87814a1f0ab72,64'h8cc702081a6439ec,
            64'h90befffa23631e28,64'ha4506cebde82bde9,64'hbef9a3f7b2c67915,64'hc67178f2e372532b,
            64'hca273eceea26619c,64'hd186b8c721c0c207,64'heada7dd6cde0eb1e,64'hf57d4f7fee6ed178,
            64'h06f067aa72176fba,64'h0a637dc5a2c898a6,64'h113f9804bef90dae,64'h1b710b35131c471b,
            64'h28db77f523047d84,64'h32caab7b40c72493,64'h3c9ebe0a15c9bebc,64'h431d67c49c100d4c,
            64'h4cc5d4becb3e42b6,64'h597f299cfc657e2a,64'h5fcb6fab3ad6faec,64'h6c44198c4a475817};
            return k[r];
        endfunction

        function void compress();
            logic [63:0] v[8];
            logic [63:0] w, w2, w15, t1, t2;
            for (int j = 0; j < 8; j++) v[j] = chain[j];
            for (int r = 0; r < 80; r++) begin
                if (r < 16) begin
                    w = window[r];
                end else begin
                    w2 = window[(r - 2) & 15];
                    w15 = window[(r - 15) & 15];
                    w = (ror(w2, 19) ^ ror(w2, 61) ^ (w2 >> 6)) + window[(r - 7) & 15]
                        + (ror(w15, 1) ^ ror(w15, 8) ^ (w15 >> 7)) + window[r & 15];
                    window[r & 15] = w;
                end
                t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(r) + w;
                t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int j = 0; j < 8; j++) chain[j] += v[j];
        endfunction

        function void push(logic [63:0] w);
            window[filled] = w;
            filled++;
            if (filled == 0) compress();
        endfunction

        function void note_word(sha512_pkg::t_in_word x);
            int n;
            int cnt;
            sha512_pkg::t_out_word o;
            logic [63:0] keep;
            if (!x.message_end) begin
                byte_total += 61'd8;
                push(x.message_word);
                return;
            end
            n = (x.byte_count > 8) ? 8 : x.byte_count;
            byte_total += 61'(n);
            if (n == 8) begin
                push(x.message_word);
                push({sha512_pkg::PAD_BYTE, 56'h0});
            end else if (n == 0) begin
                push({sha512_pkg::PAD_BYTE, 56'h0});
            end else begin
                keep = ~64'h0 << (64 - 8 * n);
                push((x.message_word & keep) | ({56'h0, sha512_pkg::PAD_BYTE} << (56 - 8 * n)));
            end
            if (filled > sha512_pkg::LEN_SLOT) push(64'h0);
            while (filled < sha512_pkg::LEN_SLOT) push(64'h0);
            push(64'h0);
            push({byte_total, 3'b000});
            cnt = sha384 ? 6 : 8;
            for (int k = 0; k < cnt; k++) begin
                o.digest_word = chain[k];
                o.digest_last = (k + 1 == cnt);
                pending.push_back(o);
            end
            load_iv();
        endfunction

        function void check_word(sha512_pkg::t_out_word got);
            sha512_pkg::t_out_word exp_w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.digest_word !== exp_w.digest_word) begin
                $display("%0t: digest_word expected %h actual %h", $time,
                         exp_w.digest_word, got.digest_word);
                errors++;
            end
            if (got.digest_last !== exp_w.digest_last) begin
                $display("%0t: digest_last expected %b actual %b", $time,
                         exp_w.digest_last, got.digest_last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    sha512_pkg::t_in_word  i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    sha512_pkg::t_out_word o_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    digest_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  no_idle = 1'b0;
    bit  hold_off = 1'b0;
    bit  sender_done = 1'b0;

    sha512_hash_engine dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_valid && o_ready) sb.note_word(i_data);
        if (o_valid && i_ready) sb.check_word(o_data);
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stalls, long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) i_ready <= 1'b0;
        else if (no_idle) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(99) >= 23);
    end

    task automatic write_mode(logic m);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_MODE; pwdata <= {31'h0, m};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_mode(m);
    endtask

    task automatic send_word(logic [63:0] w, logic [3:0] n, logic e);
        @(negedge i_clk);
        if (!no_idle) begin
            while ($urandom_range(99) < 23) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= '{message_word: w, byte_count: n, message_end: e};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_message(int len, logic [3:0] last_n);
        for (int i = 0; i < len; i++)
            send_word(rand64(), $urandom_range(15), 1'b0);
        send_word(rand64(), last_n, 1'b1);
    endtask

    int sent;
    int len;

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty, several byte counts, block-boundary lengths
        send_word(64'h0, 4'd0, 1'b1);
        send_word(64'hffffffffffffffff, 4'd15, 1'b1);
        send_word(64'h6162630000000000, 4'd3, 1'b1);
        send_word(64'hffffffffffffffff, 4'd7, 1'b0);
        send_word(64'h0123456789abcdef, 4'd8, 1'b1);
        send_message(13, 4'd8);
        send_message(14, 4'd0);
        drain();
        write_mode(1'b1);
        send_word(64'hffffffffffffffff, 4'd1, 1'b1);
        send_message(15, 4'd5);
        drain();
        // mode write mid-message abandons it
        send_word(rand64(), 4'd8, 1'b0);
        send_word(rand64(), 4'd8, 1'b0);
        repeat (300) @(negedge i_clk);
        write_mode(1'b0);

        // receiver holds off while input keeps coming
        hold_off = 1'b1;
        fork
            begin
                repeat (1500) @(negedge i_clk);
                hold_off = 1'b0;
            end
            begin
                for (int m = 0; m < 3; m++) send_message($urandom_range(20), 4'd4);
            end
        join
        drain();

        sent = 0;
        while (sent < 420) begin
            if (sent > 200 && sent < 260) no_idle = 1'b1;
            else no_idle = 1'b0;
            if ($urandom_range(9) == 0) begin
                drain();
                write_mode($urandom_range(1));
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(18);
            send_message(len, $urandom_range(15));
            sent += len + 1;
        end
        drain();
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
